>>> rtl/sthit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sthit_pkg
// shared types and constants for the shape table hit test block
// ----------------------------------------------------------------------------
package sthit_pkg;

  localparam int MaxShapes = 16;
  localparam int CntW      = $clog2(MaxShapes + 1);
  localparam int StepW     = (MaxShapes > 1) ? $clog2(MaxShapes) : 1;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_PICK    = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  localparam logic [1:0] KIND_RECT    = 2'd0;
  localparam logic [1:0] KIND_CIRCLE  = 2'd1;
  localparam logic [1:0] KIND_ELLIPSE = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] a;
    logic [15:0] b;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic done;
    logic match;
  } tst_res_t;

endpackage
`default_nettype wire

>>> rtl/shape_table_hit_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shape_table_hit_test
// table of tagged rectangles, circles and ellipses with point picking
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command word: clear the table, add a shape, or pick
//   at a point. m_axis returns exactly one result word per command.
//   the table is a row of cells, newest shape in cell 0. an add shifts the
//   row by one; a pick rotates the row one full turn, cell 0 feeding a
//   shared test unit, so newest-to-oldest order falls out of the rotation.
// sequencing:
//   clear and add: result registered in the cycle after acceptance.
//   pick: the row takes MaxShapes rotation steps; a skipped step only
//   rotates, a rectangle or early-rejected step gets a quick test, a circle
//   squares dx, dy and a, and an ellipse also squares b and forms two cross
//   products and a limit, all on the shared 32x32 multiplier.
// one command is in flight at a time; s_axis_tready is low while a pick
// runs or while an untaken result would be overwritten.
// reset: table empty, no result pending. a stalled receiver holds the
// result word in the output register until m_axis_tready.
// ----------------------------------------------------------------------------
module shape_table_hit_test (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[1:0] shape_kind[3:2] shape_tag[35:4] pos_x[51:36] pos_y[67:52]
  // size_a[83:68] size_b[99:84]
  input  wire  [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // hit[0] picked_tag[32:1] status[33]
  output logic [39:0]  m_axis_tdata
);

  localparam int Max = sthit_pkg::MaxShapes;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  // input fields
  logic [1:0]  in_mode, in_kind;
  logic [31:0] in_tag;
  logic [15:0] in_x, in_y, in_a, in_b;
  assign in_mode = s_axis_tdata[1:0];
  assign in_kind = s_axis_tdata[3:2];
  assign in_tag  = s_axis_tdata[35:4];
  assign in_x    = s_axis_tdata[51:36];
  assign in_y    = s_axis_tdata[67:52];
  assign in_a    = s_axis_tdata[83:68];
  assign in_b    = s_axis_tdata[99:84];

  logic [1:0]                  st_q, st_d;
  logic [sthit_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [sthit_pkg::StepW-1:0] step_q, step_d;
  logic                        hit_q, hit_d;
  logic [31:0]                 tag_q, tag_d;
  logic [15:0]                 px_q, py_q;
  logic                        ov_q, ov_d;
  logic                        o_hit_q, o_hit_d, o_stat_q, o_stat_d;
  logic [31:0]                 o_tag_q, o_tag_d;

  logic                acc, shift, rot, tst_start, full, need_test, last_step;
  sthit_pkg::entry_t   new_ent;
  sthit_pkg::entry_t   row [Max];
  sthit_pkg::tst_res_t tst;

  assign s_axis_tready = (st_q == ST_IDLE) && (!ov_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q >= sthit_pkg::CntW'(Max));
  assign need_test     = (sthit_pkg::CntW'(step_q) < cnt_q) && !hit_q;
  assign last_step     = (step_q == sthit_pkg::StepW'(Max - 1));

  assign new_ent = '{kind: in_kind, x0: in_x, y0: in_y, a: in_a, b: in_b, tag: in_tag};

  // add shifts new shape into cell 0, only when it is stored
  assign shift = acc && (in_mode == sthit_pkg::MODE_ADD) && !full &&
                 (in_kind != sthit_pkg::KIND_UNKNOWN);

  // the row of cells
  for (genvar i = 0; i < Max; i++) begin : g_cell
    sthit_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .rot_i   (rot),
      .prev_i  ((i == 0) ? new_ent : row[(i + Max - 1) % Max]),
      .next_i  (row[(i + 1) % Max]),
      .ent_o   (row[i])
    );
  end

  sthit_test u_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tst_start),
    .ent_i   (row[0]),
    .px_i    (px_q),
    .py_i    (py_q),
    .res_o   (tst)
  );

  // control sequencer
  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    hit_d     = hit_q;
    tag_d     = tag_q;
    ov_d      = ov_q && !m_axis_tready;
    o_hit_d   = o_hit_q;
    o_tag_d   = o_tag_q;
    o_stat_d  = o_stat_q;
    rot       = 1'b0;
    tst_start = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (acc) begin
          o_hit_d  = 1'b0;
          o_tag_d  = 32'd0;
          o_stat_d = 1'b0;
          case (in_mode)
            sthit_pkg::MODE_CLEAR: begin
              cnt_d = '0;
              ov_d  = 1'b1;
            end
            sthit_pkg::MODE_ADD: begin
              if (full) begin
                o_stat_d = 1'b1;
              end else if (in_kind != sthit_pkg::KIND_UNKNOWN) begin
                cnt_d = cnt_q + 1'b1;
              end
              ov_d = 1'b1;
            end
            sthit_pkg::MODE_PICK: begin
              st_d   = ST_STEP;
              step_d = '0;
              hit_d  = 1'b0;
              tag_d  = 32'd0;
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      ST_STEP: begin
        if (need_test) begin
          tst_start = 1'b1;
          st_d      = ST_WAIT;
        end else begin
          rot = 1'b1;
          if (last_step) begin
            st_d    = ST_IDLE;
            ov_d    = 1'b1;
            o_hit_d = hit_q;
            o_tag_d = tag_q;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (tst.done) begin
          if (tst.match) begin
            hit_d = 1'b1;
            tag_d = row[0].tag;
          end
          // tested entry done, move on to the next one
          rot = 1'b1;
          if (last_step) begin
            st_d    = ST_IDLE;
            ov_d    = 1'b1;
            o_hit_d = hit_d;
            o_tag_d = tag_d;
          end else begin
            step_d = step_q + 1'b1;
            st_d   = ST_STEP;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      step_q <= '0;
      hit_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      step_q <= step_d;
      hit_q  <= hit_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    o_hit_q  <= o_hit_d;
    o_tag_q  <= o_tag_d;
    o_stat_q <= o_stat_d;
    if (acc) begin
      px_q <= in_x;
      py_q <= in_y;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, o_stat_q, o_tag_q, o_hit_q};

  // checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sthit_pkg::CntW'(Max))
    else $error("entry count above table size");

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tst.done |-> (st_q == ST_WAIT))
    else $error("test unit finished outside a wait");

  a_full_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_mode == sthit_pkg::MODE_ADD) && full) |=> (ov_q && o_stat_q))
    else $error("add on full table not rejected");

  a_no_shift_in_pick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !shift)
    else $error("table shifted during a pick");

endmodule
`default_nettype wire

>>> rtl/sthit_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sthit_cell
// one table entry; shifts toward the old end on add, rotates back on pick
// ----------------------------------------------------------------------------
module sthit_cell (
  input  wire               clk_i,
  input  wire               shift_i,
  input  wire               rot_i,
  input  sthit_pkg::entry_t prev_i,
  input  sthit_pkg::entry_t next_i,
  output sthit_pkg::entry_t ent_o
);

  sthit_pkg::entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= prev_i;
    end else if (rot_i) begin
      ent_q <= next_i;
    end
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

>>> rtl/sthit_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sthit_test
// point-in-shape test for one entry on a shared 32x32 multiplier
// ----------------------------------------------------------------------------
module sthit_test (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  sthit_pkg::entry_t    ent_i,
  input  wire         [15:0]   px_i,
  input  wire         [15:0]   py_i,
  output sthit_pkg::tst_res_t  res_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DX2  = 3'd1;
  localparam logic [2:0] PH_DY2  = 3'd2;
  localparam logic [2:0] PH_A2   = 3'd3;
  localparam logic [2:0] PH_B2   = 3'd4;
  localparam logic [2:0] PH_T1   = 3'd5;
  localparam logic [2:0] PH_T2   = 3'd6;
  localparam logic [2:0] PH_LIM  = 3'd7;

  logic [2:0]  ph_q, ph_d;
  logic        done_q, done_d, match_q, match_d;
  logic        circ_q;
  logic [15:0] dx_q, dy_q, a_q, b_q;
  logic [31:0] dx2_q, dy2_q, a2_q, b2_q;
  logic [63:0] t1_q, t2_q;

  logic signed [17:0] x0s, y0s, pxs, pys, as, bs, rys, cx, cy, ddx, ddy;
  logic        [17:0] adx, ady;
  logic               in_rect, dx_big, dy_big, is_circ, quick_match, go_long;
  logic        [31:0] mul_a, mul_b;
  logic        [63:0] prod;
  logic        [64:0] ell_sum;
  logic        [32:0] circ_sum;

  always_comb begin
    x0s = {{2{ent_i.x0[15]}}, ent_i.x0};
    y0s = {{2{ent_i.y0[15]}}, ent_i.y0};
    pxs = {{2{px_i[15]}}, px_i};
    pys = {{2{py_i[15]}}, py_i};
    as  = {2'b00, ent_i.a};
    bs  = {2'b00, ent_i.b};
    is_circ = (ent_i.kind == sthit_pkg::KIND_CIRCLE);
    rys = is_circ ? as : bs;
    cx  = x0s + as;
    cy  = y0s + rys;
    ddx = cx - pxs;
    ddy = cy - pys;
    adx = ddx[17] ? 18'(-ddx) : 18'(ddx);
    ady = ddy[17] ? 18'(-ddy) : 18'(ddy);
    dx_big = adx > 18'(as);
    dy_big = ady > 18'(rys);
    in_rect = (pxs >= x0s) && (pxs < x0s + as) && (pys >= y0s) && (pys < y0s + bs);
    quick_match = 1'b0;
    go_long     = 1'b0;
    case (ent_i.kind)
      sthit_pkg::KIND_RECT:    quick_match = in_rect;
      sthit_pkg::KIND_CIRCLE:  go_long = !dx_big && !dy_big;
      sthit_pkg::KIND_ELLIPSE: go_long = !dx_big && !dy_big &&
                                         (ent_i.a != 16'd0) && (ent_i.b != 16'd0);
      default:                 quick_match = 1'b0;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (ph_q)
      PH_DX2:  begin mul_a = {16'd0, dx_q}; mul_b = {16'd0, dx_q}; end
      PH_DY2:  begin mul_a = {16'd0, dy_q}; mul_b = {16'd0, dy_q}; end
      PH_A2:   begin mul_a = {16'd0, a_q};  mul_b = {16'd0, a_q};  end
      PH_B2:   begin mul_a = {16'd0, b_q};  mul_b = {16'd0, b_q};  end
      PH_T1:   begin mul_a = dx2_q;         mul_b = b2_q;          end
      PH_T2:   begin mul_a = dy2_q;         mul_b = a2_q;          end
      PH_LIM:  begin mul_a = a2_q;          mul_b = b2_q;          end
      default: begin mul_a = 32'd0;         mul_b = 32'd0;         end
    endcase
    prod     = mul_a * mul_b;
    circ_sum = {1'b0, dx2_q} + {1'b0, dy2_q};
    ell_sum  = {1'b0, t1_q} + {1'b0, t2_q};
  end

  always_comb begin
    ph_d    = ph_q;
    done_d  = 1'b0;
    match_d = match_q;
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          if (go_long) begin
            ph_d = PH_DX2;
          end else begin
            done_d  = 1'b1;
            match_d = quick_match;
          end
        end
      end
      PH_A2: begin
        if (circ_q) begin
          ph_d    = PH_IDLE;
          done_d  = 1'b1;
          match_d = (circ_sum <= {1'b0, prod[31:0]});
        end else begin
          ph_d = PH_B2;
        end
      end
      PH_LIM: begin
        ph_d    = PH_IDLE;
        done_d  = 1'b1;
        match_d = (ell_sum <= {1'b0, prod});
      end
      default: ph_d = ph_q + 3'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      done_q  <= 1'b0;
      match_q <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      done_q  <= done_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && start_i) begin
      circ_q <= is_circ;
      dx_q   <= adx[15:0];
      dy_q   <= ady[15:0];
      a_q    <= ent_i.a;
      b_q    <= ent_i.b;
    end
    case (ph_q)
      PH_DX2:  dx2_q <= prod[31:0];
      PH_DY2:  dy2_q <= prod[31:0];
      PH_A2:   a2_q  <= prod[31:0];
      PH_B2:   b2_q  <= prod[31:0];
      PH_T1:   t1_q  <= prod;
      PH_T2:   t2_q  <= prod;
      default: ;
    endcase
  end

  assign res_o = '{done: done_q, match: match_q};

endmodule
`default_nettype wire
